>>> hdl/tpna_pkg.sv
package tpna_pkg;

  // defaults for the top-level parameters
  localparam int MAX_SIDE_TILES_DFLT = 4;
  localparam int STORE_BYTES_DFLT    = 512;
  localparam int QUEUE_DEPTH_DFLT    = 2;

  // fixed field widths
  localparam int OP_W    = 2;
  localparam int COORD_W = 5;
  localparam int NIB_W   = 4;
  localparam int LADDR_W = 9;
  localparam int BYTE_W  = 8;
  localparam int SIDE_W  = 4;   // saturated side in tiles, up to MAX_SIDE_TILES
  localparam int OFF_W   = 12;  // byte offset before the store-size check
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 3;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_H = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_V = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOADED   = 3'd4;

  // one classified request, front to back
  typedef struct packed {
    logic              hit;
    logic              is_load;
    logic              is_write;
    logic              odd;
    logic [OFF_W-1:0]  addr;
    logic [BYTE_W-1:0] data;   // load byte, or pixel value in the low nibble
  } req_t;

endpackage

>>> hdl/tpna_ram.sv
module tpna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/tpna_front.sv
module tpna_front import tpna_pkg::*; #(
  parameter int MAX_SIDE_TILES = MAX_SIDE_TILES_DFLT,
  parameter int STORE_BYTES    = STORE_BYTES_DFLT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  start,
  input  logic                  q_full,
  input  logic [OP_W-1:0]       in_op,
  input  logic [COORD_W-1:0]    in_pixel_x,
  input  logic [COORD_W-1:0]    in_pixel_y,
  input  logic [NIB_W-1:0]      in_pixel_value,
  input  logic [LADDR_W-1:0]    in_load_address,
  input  logic [BYTE_W-1:0]     in_load_byte,
  output logic                  busy,
  output logic                  push,
  output req_t                  req
);

  localparam logic [SIDE_W-1:0] MaxSide  = SIDE_W'(MAX_SIDE_TILES);
  localparam logic [OFF_W-1:0]  StoreLim = OFF_W'(STORE_BYTES);

  logic [2:0] width_r, height_r;
  logic       mirror_h_r, mirror_v_r, loaded_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= 3'd1;
      height_r   <= 3'd1;
      mirror_h_r <= 1'b0;
      mirror_v_r <= 1'b0;
      loaded_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:    width_r    <= cfg_wdata;
        CFG_HEIGHT:   height_r   <= cfg_wdata;
        CFG_MIRROR_H: mirror_h_r <= cfg_wdata[0];
        CFG_MIRROR_V: mirror_v_r <= cfg_wdata[0];
        CFG_LOADED:   loaded_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic [SIDE_W-1:0] w_sat, h_sat;
  logic [6:0]        tw, th, x_ext, y_ext, rx, ry;
  logic              x_out, y_out, pix_hit;
  logic [6:0]        tile;
  logic [OFF_W-1:0]  off, la_ext;

  always_comb begin
    w_sat = ({1'b0, width_r} > MaxSide) ? MaxSide : {1'b0, width_r};
    h_sat = ({1'b0, height_r} > MaxSide) ? MaxSide : {1'b0, height_r};
    tw    = {w_sat, 3'b000};
    th    = {h_sat, 3'b000};
    x_ext = {2'b00, in_pixel_x};
    y_ext = {2'b00, in_pixel_y};
    // undo the flips; a flipped coordinate past the edge misses
    rx = mirror_h_r ? (tw - 7'd1 - x_ext) : x_ext;
    ry = mirror_v_r ? (th - 7'd1 - y_ext) : y_ext;
    x_out = (x_ext >= tw) || (rx >= tw);
    y_out = (y_ext >= th) || (ry >= th);
    // tiles are column-major: col * height + row
    tile = 7'(rx[5:3] * h_sat) + {4'b0000, ry[5:3]};
    off  = {tile, 5'b00000} + {7'b0, ry[2:0], 2'b00} + {10'b0, rx[2:1]};
    pix_hit = loaded_r && !x_out && !y_out && (off < StoreLim);
    la_ext  = OFF_W'(in_load_address);

    req = '0;
    unique case (in_op) inside
      OP_LOAD: begin
        req.hit     = la_ext < StoreLim;
        req.is_load = 1'b1;
        req.addr    = la_ext;
        req.data    = in_load_byte;
      end
      OP_READ, OP_WRITE: begin
        req.hit      = pix_hit;
        req.is_write = (in_op == OP_WRITE);
        req.odd      = rx[0];
        req.addr     = off;
        req.data     = {4'b0000, in_pixel_value};
      end
      default: ;
    endcase
  end

  assign busy = q_full;
  assign push = start && !q_full;

endmodule

>>> hdl/tpna_queue.sv
module tpna_queue import tpna_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DFLT
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_req,
  input  logic pop,
  output logic empty,
  output logic full,
  output req_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  req_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == FullCnt);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

>>> hdl/tpna_back.sv
module tpna_back import tpna_pkg::*; #(
  parameter int STORE_BYTES = STORE_BYTES_DFLT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  req_t             head,
  output logic             pop,
  output logic             out_strobe,
  output logic [NIB_W-1:0] out_old_value,
  output logic             out_in_range
);

  localparam int AW = $clog2(STORE_BYTES);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WB   = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  req_t              cur_r;
  logic [BYTE_W-1:0] rd_data, wr_data;
  logic              wr_en;
  logic [NIB_W-1:0]  old_nib;
  logic              strobe_r;
  logic [NIB_W-1:0]  old_r;
  logic              range_r;

  assign pop = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (!q_empty) state_nxt = S_WB;
      S_WB:    state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // read issued on pop, write-back in the following cycle once the byte is back
  tpna_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(cur_r.addr[AW-1:0]),
    .wr_data(wr_data),
    .rd_addr(head.addr[AW-1:0]),
    .rd_data(rd_data)
  );

  always_comb begin
    old_nib = cur_r.odd ? rd_data[3:0] : rd_data[7:4];
    if (cur_r.is_load) begin
      wr_data = cur_r.data;
    end else if (cur_r.odd) begin
      wr_data = {rd_data[7:4], cur_r.data[3:0]};
    end else begin
      wr_data = {cur_r.data[3:0], rd_data[3:0]};
    end
    wr_en = (state_r == S_WB) && cur_r.hit && (cur_r.is_load || cur_r.is_write);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == S_WB);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
    if (state_r == S_WB) begin
      range_r <= cur_r.hit;
      old_r   <= (cur_r.hit && !cur_r.is_load) ? old_nib : '0;
    end
  end

  assign out_strobe    = strobe_r;
  assign out_old_value = old_r;
  assign out_in_range  = range_r;

endmodule

>>> hdl/tile_pixel_nibble_access_core.sv
// Tile pixel store of one 4bpp sprite. A request is taken when start is high
// and busy is low. The back end handles one request at a time (store read,
// then nibble write-back) and takes no new one until that one is done.
// Up to QUEUE_DEPTH classified requests wait between address decode and the
// store; busy rises while that queue is full. Each result shows on out_ for
// exactly one cycle with out_strobe and cannot be held off. Results come
// back in request order. The store is not cleared: load bytes before
// reading them. Write cfg_ registers only while nothing is in flight.
module tile_pixel_nibble_access_core import tpna_pkg::*; #(
  parameter int MAX_SIDE_TILES = MAX_SIDE_TILES_DFLT,
  parameter int STORE_BYTES    = STORE_BYTES_DFLT,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DFLT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       in_op,
  input  logic [COORD_W-1:0]    in_pixel_x,
  input  logic [COORD_W-1:0]    in_pixel_y,
  input  logic [NIB_W-1:0]      in_pixel_value,
  input  logic [LADDR_W-1:0]    in_load_address,
  input  logic [BYTE_W-1:0]     in_load_byte,
  output logic                  out_strobe,
  output logic [NIB_W-1:0]      out_old_value,
  output logic                  out_in_range
);

  req_t push_req, head;
  logic push, pop, q_empty, q_full;

  tpna_front #(
    .MAX_SIDE_TILES(MAX_SIDE_TILES),
    .STORE_BYTES   (STORE_BYTES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .start          (start),
    .q_full         (q_full),
    .in_op          (in_op),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .in_pixel_value (in_pixel_value),
    .in_load_address(in_load_address),
    .in_load_byte   (in_load_byte),
    .busy           (busy),
    .push           (push),
    .req            (push_req)
  );

  tpna_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_req(push_req),
    .pop     (pop),
    .empty   (q_empty),
    .full    (q_full),
    .head    (head)
  );

  tpna_back #(
    .STORE_BYTES(STORE_BYTES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .out_strobe   (out_strobe),
    .out_old_value(out_old_value),
    .out_in_range (out_in_range)
  );

endmodule

>>> sim/tile_pixel_nibble_access_core_test.sv
`timescale 1ns / 100ps

module tile_pixel_nibble_access_core_test;
  import tpna_pkg::*;

  localparam int MAX_SIDE    = MAX_SIDE_TILES_DFLT;
  localparam int STORE_BYTES = STORE_BYTES_DFLT;
  localparam int TILE_PIX    = 8;
  localparam int TILE_BYTES  = 32;
  localparam int ROW_BYTES   = 4;
  localparam int TOTAL_REQ   = 1900;

  // op 3 is decoded as a no-op
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [NIB_W-1:0]   val;
    logic [LADDR_W-1:0] addr;
    logic [BYTE_W-1:0]  data;
  } pix_req_t;

  typedef struct packed {
    logic [NIB_W-1:0] old_value;
    logic             in_range;
  } pix_result_t;

  typedef enum logic {ROW_REQ, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [OP_W-1:0]       op;
    logic [COORD_W-1:0]    x;
    logic [COORD_W-1:0]    y;
    logic [NIB_W-1:0]      val;
    logic [LADDR_W-1:0]    addr;
    logic [BYTE_W-1:0]     data;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  typed;
    logic [NIB_W-1:0]      exp_old;
    logic                  exp_hit;
  } dir_row_t;

  localparam int DIR_N = 33;

  // kind, op, x, y, value, load addr, load byte, reg, reg data, typed, old, hit
  dir_row_t dir_rows [DIR_N] = '{
    '{ROW_REQ, OP_READ,  5'd0,  5'd0,  4'h0, 9'd0,   8'h00, CFG_WIDTH,    3'd0, 1'b1, 4'h0, 1'b0},
    '{ROW_REQ, OP_WRITE, 5'd0,  5'd0,  4'hF, 9'd0,   8'h00, CFG_WIDTH,    3'd0, 1'b1, 4'h0, 1'b0},
    '{ROW_REQ, OP_NONE,  5'd31, 5'd31, 4'hF, 9'd511, 8'hFF, CFG_WIDTH,    3'd0, 1'b1, 4'h0, 1'b0},
    '{ROW_REQ, OP_LOAD,  5'd0,  5'd0,  4'h0, 9'd0,   8'hA5, CFG_WIDTH,    3'd0, 1'b1, 4'h0, 1'b1},
    '{ROW_REQ, OP_LOAD,  5'd0,  5'd0,  4'h0, 9'd511, 8'hFF, CFG_WIDTH,    3'd0, 1'b1, 4'h0, 1'b1},
    '{ROW_REQ, OP_LOAD,  5'd0,  5'd0,  4'h0, 9'd3,   8'h00, CFG_WIDTH,    3'd0, 1'b1, 4'h0, 1'b1},
    '{ROW_REQ, OP_LOAD,  5'd0,  5'd0,  4'h0, 9'd28,  8'h5A, CFG_WIDTH,    3'd0, 1'b1, 4'h0, 1'b1},
    '{ROW_REQ, OP_LOAD,  5'd0,  5'd0,  4'h0, 9'd31,  8'h96, CFG_WIDTH,    3'd0, 1'b1, 4'h0, 1'b1},
    '{ROW_REG, OP_LOAD,  5'd0,  5'd0,  4'h0, 9'd0,   8'h00, CFG_LOADED,   3'd1, 1'b0, 4'h0, 1'b0},
    '{ROW_REQ, OP_READ,  5'd0,  5'd0,  4'h0, 9'd0,   8'h00, CFG_WIDTH,    3'd0, 1'b1, 4'hA, 1'b1},
    '{ROW_REQ, OP_READ,  5'd1,  5'd0,  4'h0, 9'd0,   8'h00, CFG_WIDTH,    3'd0, 1'b1, 4'h5, 1'b1},
    '{ROW_REQ, OP_WRITE, 5'd1,  5'd0,  4'h0, 9'd0,   8'h00, CFG_WIDTH,    3'd0, 1'b1, 4'h5, 1'b1},
    '{ROW_REQ, OP_READ,  5'd1,  5'd0,  4'h0, 9'd0,   8'h00, CFG_WIDTH,    3'd0, 1'b1, 4'h0, 1'b1},
    '{ROW_REQ, OP_READ,  5'd7,  5'd0,  4'h0, 9'd0,   8'h00, CFG_WIDTH,    3'd0, 1'b1, 4'h0, 1'b1},
    '{ROW_REQ, OP_READ,  5'd8,  5'd0,  4'h0, 9'd0,   8'h00, CFG_WIDTH,    3'd0, 1'b1, 4'h0, 1'b0},
    '{ROW_REQ, OP_READ,  5'd31, 5'd31, 4'h0, 9'd0,   8'h00, CFG_WIDTH,    3'd0, 1'b1, 4'h0, 1'b0},
    '{ROW_REG, OP_LOAD,  5'd0,  5'd0,  4'h0, 9'd0,   8'h00, CFG_MIRROR_H, 3'd1, 1'b0, 4'h0, 1'b0},
    '{ROW_REG, OP_LOAD,  5'd0,  5'd0,  4'h0, 9'd0,   8'h00, CFG_MIRROR_V, 3'd1, 1'b0, 4'h0, 1'b0},
    '{ROW_REQ, OP_READ,  5'd0,  5'd0,  4'h0, 9'd0,   8'h00, CFG_WIDTH,    3'd0, 1'b1, 4'h6, 1'b1},
    '{ROW_REQ, OP_WRITE, 5'd31, 5'd0,  4'hF, 9'd0,   8'h00, CFG_WIDTH,    3'd0, 1'b1, 4'h0, 1'b0},
    '{ROW_REQ, OP_READ,  5'd7,  5'd7,  4'h0, 9'd0,   8'h00, CFG_WIDTH,    3'd0, 1'b1, 4'hA, 1'b1},
    '{ROW_REQ, OP_READ,  5'd1,  5'd0,  4'h0, 9'd0,   8'h00, CFG_WIDTH,    3'd0, 1'b1, 4'h9, 1'b1},
    '{ROW_REG, OP_LOAD,  5'd0,  5'd0,  4'h0, 9'd0,   8'h00, CFG_WIDTH,    3'd0, 1'b0, 4'h0, 1'b0},
    '{ROW_REQ, OP_READ,  5'd0,  5'd0,  4'h0, 9'd0,   8'h00, CFG_WIDTH,    3'd0, 1'b1, 4'h0, 1'b0},
    '{ROW_REG, OP_LOAD,  5'd0,  5'd0,  4'h0, 9'd0,   8'h00, CFG_MIRROR_H, 3'd0, 1'b0, 4'h0, 1'b0},
    '{ROW_REG, OP_LOAD,  5'd0,  5'd0,  4'h0, 9'd0,   8'h00, CFG_MIRROR_V, 3'd0, 1'b0, 4'h0, 1'b0},
    '{ROW_REG, OP_LOAD,  5'd0,  5'd0,  4'h0, 9'd0,   8'h00, CFG_WIDTH,    3'd7, 1'b0, 4'h0, 1'b0},
    '{ROW_REG, OP_LOAD,  5'd0,  5'd0,  4'h0, 9'd0,   8'h00, CFG_HEIGHT,   3'd7, 1'b0, 4'h0, 1'b0},
    '{ROW_REQ, OP_READ,  5'd31, 5'd31, 4'h0, 9'd0,   8'h00, CFG_WIDTH,    3'd0, 1'b1, 4'hF, 1'b1},
    '{ROW_REQ, OP_WRITE, 5'd31, 5'd31, 4'hA, 9'd0,   8'h00, CFG_WIDTH,    3'd0, 1'b1, 4'hF, 1'b1},
    '{ROW_REQ, OP_READ,  5'd30, 5'd31, 4'h0, 9'd0,   8'h00, CFG_WIDTH,    3'd0, 1'b1, 4'hF, 1'b1},
    '{ROW_REQ, OP_READ,  5'd31, 5'd31, 4'h0, 9'd0,   8'h00, CFG_WIDTH,    3'd0, 1'b1, 4'hA, 1'b1},
    '{ROW_REQ, OP_WRITE, 5'd7,  5'd7,  4'h5, 9'd0,   8'h00, CFG_WIDTH,    3'd0, 1'b0, 4'h0, 1'b0}
  };

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [OP_W-1:0]       in_op = OP_LOAD;
  logic [COORD_W-1:0]    in_pixel_x = '0;
  logic [COORD_W-1:0]    in_pixel_y = '0;
  logic [NIB_W-1:0]      in_pixel_value = '0;
  logic [LADDR_W-1:0]    in_load_address = '0;
  logic [BYTE_W-1:0]     in_load_byte = '0;
  logic                  out_strobe;
  logic [NIB_W-1:0]      out_old_value;
  logic                  out_in_range;

  // local copy of the sprite registers and the tile store
  logic [CFG_DATA_W-1:0] reg_width = 3'd1;
  logic [CFG_DATA_W-1:0] reg_height = 3'd1;
  logic                  reg_mirror_h = 1'b0;
  logic                  reg_mirror_v = 1'b0;
  logic                  reg_loaded = 1'b0;
  logic [BYTE_W-1:0]     tile_mem [STORE_BYTES];
  bit                    tile_known [STORE_BYTES];

  pix_result_t pending_results [$];

  int unsigned n_requests, n_loads, n_reads, n_writes, n_unused, n_hits;
  int unsigned n_results, n_settings, n_fails;

  tile_pixel_nibble_access_core #(
    .MAX_SIDE_TILES (MAX_SIDE_TILES_DFLT),
    .STORE_BYTES    (STORE_BYTES_DFLT),
    .QUEUE_DEPTH    (QUEUE_DEPTH_DFLT)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_pixel_value  (in_pixel_value),
    .in_load_address (in_load_address),
    .in_load_byte    (in_load_byte),
    .out_strobe      (out_strobe),
    .out_old_value   (out_old_value),
    .out_in_range    (out_in_range)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tile_pixel_nibble_access_core_test: FAIL");
    $finish;
  end

  function automatic int unsigned side_sat(input logic [CFG_DATA_W-1:0] v);
    return (v > MAX_SIDE) ? MAX_SIDE : int'(v);
  endfunction

  // Undo the flips and find the byte and nibble of a display pixel.
  function automatic bit pixel_locate(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                      output int unsigned addr, output bit odd);
    int unsigned h, tw, th, rx, ry, tile, off;
    h = side_sat(reg_height);
    tw = side_sat(reg_width) * TILE_PIX;
    th = h * TILE_PIX;
    addr = 0;
    odd = 1'b0;
    if (!reg_loaded || tw == 0 || th == 0) return 1'b0;
    if (reg_mirror_h) begin
      if (x >= tw) return 1'b0;
      rx = tw - 1 - x;
    end else begin
      rx = x;
    end
    if (reg_mirror_v) begin
      if (y >= th) return 1'b0;
      ry = th - 1 - y;
    end else begin
      ry = y;
    end
    if (rx >= tw || ry >= th) return 1'b0;
    tile = (rx / TILE_PIX) * h + ry / TILE_PIX;
    off = tile * TILE_BYTES + (ry % TILE_PIX) * ROW_BYTES + (rx % TILE_PIX) / 2;
    if (off >= STORE_BYTES) return 1'b0;
    addr = off;
    odd = rx[0];
    return 1'b1;
  endfunction

  // Applies one request to the local store and returns the result it gives.
  function automatic pix_result_t apply_request(input pix_req_t r);
    pix_result_t res;
    int unsigned addr;
    bit odd;
    logic [BYTE_W-1:0] b;
    res = '0;
    case (r.op) inside
      OP_LOAD: begin
        if (r.addr < STORE_BYTES) begin
          tile_mem[r.addr] = r.data;
          tile_known[r.addr] = 1'b1;
          res.in_range = 1'b1;
        end
      end
      OP_READ, OP_WRITE: begin
        if (pixel_locate(r.x, r.y, addr, odd)) begin
          b = tile_mem[addr];
          res.in_range = 1'b1;
          res.old_value = odd ? b[3:0] : b[7:4];
          if (r.op == OP_WRITE) begin
            if (odd) b[3:0] = r.val;
            else b[7:4] = r.val;
            tile_mem[addr] = b;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_side();
    int unsigned k;
    k = $urandom_range(0, 15);
    if (k == 0) return '0;
    if (k == 1) return CFG_DATA_W'($urandom_range(MAX_SIDE + 1, 7));
    return CFG_DATA_W'($urandom_range(1, MAX_SIDE));
  endfunction

  // mostly inside the sprite, now and then anywhere on the 32x32 grid
  function automatic logic [COORD_W-1:0] pick_coord(input logic [CFG_DATA_W-1:0] side);
    int unsigned span;
    span = side_sat(side) * TILE_PIX;
    if (span == 0 || $urandom_range(0, 5) == 0) return COORD_W'($urandom_range(0, 31));
    return COORD_W'($urandom_range(0, span - 1));
  endfunction

  function automatic pix_req_t random_request();
    pix_req_t r;
    int unsigned k, addr;
    bit odd;
    k = $urandom_range(0, 19);
    r.op = (k < 5) ? OP_LOAD : (k < 12) ? OP_READ : (k < 19) ? OP_WRITE : OP_NONE;
    r.x = pick_coord(reg_width);
    r.y = pick_coord(reg_height);
    r.val = NIB_W'($urandom);
    r.addr = LADDR_W'($urandom);
    r.data = BYTE_W'($urandom);
    // a pixel on a byte never loaded becomes a load of that byte
    if ((r.op == OP_READ || r.op == OP_WRITE) && pixel_locate(r.x, r.y, addr, odd)
        && !tile_known[addr]) begin
      r.op = OP_LOAD;
      r.addr = LADDR_W'(addr);
    end
    return r;
  endfunction

  task automatic send_request(input pix_req_t r, input logic typed, input pix_result_t typed_res);
    pix_result_t res;
    start <= 1'b1;
    in_op <= r.op;
    in_pixel_x <= r.x;
    in_pixel_y <= r.y;
    in_pixel_value <= r.val;
    in_load_address <= r.addr;
    in_load_byte <= r.data;
    do @(posedge clk); while (busy !== 1'b0);
    res = apply_request(r);
    pending_results.push_back(typed ? typed_res : res);
    n_requests++;
    if (res.in_range) n_hits++;
    case (r.op)
      OP_LOAD:  n_loads++;
      OP_READ:  n_reads++;
      OP_WRITE: n_writes++;
      default:  n_unused++;
    endcase
  endtask

  task automatic idle_gap(input bit burst);
    int unsigned k, n;
    k = $urandom_range(0, 19);
    if (burst || k < 11) n = 0;
    else if (k < 18) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_WIDTH:    reg_width = data;
      CFG_HEIGHT:   reg_height = data;
      CFG_MIRROR_H: reg_mirror_h = data[0];
      CFG_MIRROR_V: reg_mirror_v = data[0];
      CFG_LOADED:   reg_loaded = data[0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : check_results
    pix_result_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: old_value %0h, in_range %0b",
               out_old_value, out_in_range);
        n_fails++;
      end else begin
        want = pending_results.pop_front();
        if (out_old_value !== want.old_value) begin
          $error("old_value: expected %0h, got %0h", want.old_value, out_old_value);
          n_fails++;
        end
        if (out_in_range !== want.in_range) begin
          $error("in_range: expected %0b, got %0b", want.in_range, out_in_range);
          n_fails++;
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t row;
    pix_req_t r;
    pix_result_t typed_res;
    int unsigned n;
    bit burst;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_REG) begin
        wait_idle();
        write_reg(row.reg_idx, row.reg_val);
        cfg_we <= 1'b0;
        n_settings++;
      end else begin
        r = '{op: row.op, x: row.x, y: row.y, val: row.val, addr: row.addr, data: row.data};
        typed_res = '{old_value: row.exp_old, in_range: row.exp_hit};
        send_request(r, row.typed, typed_res);
        idle_gap(1'b0);
      end
    end

    while (n_requests < TOTAL_REQ) begin
      wait_idle();
      write_reg(CFG_WIDTH, pick_side());
      write_reg(CFG_HEIGHT, pick_side());
      write_reg(CFG_MIRROR_H, CFG_DATA_W'($urandom_range(0, 1)));
      write_reg(CFG_MIRROR_V, CFG_DATA_W'($urandom_range(0, 1)));
      write_reg(CFG_LOADED, CFG_DATA_W'($urandom_range(0, 9) != 0));
      cfg_we <= 1'b0;
      n_settings++;
      burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(40, 160);
      for (int i = 0; i < n && n_requests < TOTAL_REQ; i++) begin
        send_request(random_request(), 1'b0, '0);
        idle_gap(burst);
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);

    $display("Sent %0d requests (%0d loads, %0d reads, %0d writes, %0d unused op) over %0d settings;",
             n_requests, n_loads, n_reads, n_writes, n_unused, n_settings);
    $display("%0d landed in the sprite or store, %0d results compared.", n_hits, n_results);
    if (n_fails == 0) begin
      $display("tile_pixel_nibble_access_core_test: PASS");
    end else begin
      $display("tile_pixel_nibble_access_core_test: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/tpna_pkg.sv
hdl/tpna_ram.sv
hdl/tpna_front.sv
hdl/tpna_queue.sv
hdl/tpna_back.sv
hdl/tile_pixel_nibble_access_core.sv
sim/tile_pixel_nibble_access_core_test.sv
